>>> rtl/u16d_pkg.sv
package u16d_pkg;

  // surrogate ranges and special units
  localparam logic [15:0] HiSurFirst  = 16'hD800;
  localparam logic [15:0] HiSurLast   = 16'hDBFF;
  localparam logic [15:0] LoSurFirst  = 16'hDC00;
  localparam logic [15:0] LoSurLast   = 16'hDFFF;
  localparam logic [15:0] ReplUnit    = 16'hFFFD;
  localparam logic [15:0] SwappedMark = 16'hFFFE;

  // result buffer depth: two beats waiting plus two new results
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);
  localparam int unsigned ResIdxW  = $clog2(ResDepth);

  // one result beat
  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        last_of_run;
  } res_t;

  // results produced by one input beat
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic is_high(input logic [15:0] u);
    return (u >= HiSurFirst) && (u <= HiSurLast);
  endfunction

  function automatic logic is_low(input logic [15:0] u);
    return (u >= LoSurFirst) && (u <= LoSurLast);
  endfunction

endpackage

>>> rtl/u16d_if.sv
interface u16d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface u16d_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        replaced;
  logic        last_of_run;

  modport source (output valid, output code_unit, output replaced, output last_of_run,
                  input ready);
  modport sink (input valid, input code_unit, input replaced, input last_of_run,
                output ready);
endinterface

>>> rtl/u16d_res_buf.sv
module u16d_res_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u16d_pkg::push_t   push_i,
  input  logic              pop_i,
  output logic              free_o,
  output logic              valid_o,
  output u16d_pkg::res_t    head_o
);

  u16d_pkg::res_t                      ent_q [u16d_pkg::ResDepth];
  u16d_pkg::res_t                      ent_d [u16d_pkg::ResDepth];
  logic [u16d_pkg::ResCntW-1:0]        cnt_q, cnt_d, cnt_after;

  // room for a full beat of results whatever the sink does
  assign free_o  = (cnt_q <= u16d_pkg::ResCntW'(u16d_pkg::ResDepth - 2));
  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[0];

  // shift out the head, then append new results behind what is left
  always_comb begin
    cnt_after = cnt_q - u16d_pkg::ResCntW'(pop_i);
    for (int i = 0; i < u16d_pkg::ResDepth; i++) begin
      if (pop_i && (i < u16d_pkg::ResDepth - 1)) begin
        ent_d[i] = ent_q[i + 1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if ((push_i.num != 2'd0) && (u16d_pkg::ResCntW'(i) == cnt_after)) begin
        ent_d[i] = push_i.first;
      end
      if ((push_i.num == 2'd2) && (u16d_pkg::ResCntW'(i) == cnt_after + 1'b1)) begin
        ent_d[i] = push_i.second;
      end
    end
    cnt_d = cnt_after + u16d_pkg::ResCntW'(push_i.num);
  end

  // count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // payload entries
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < u16d_pkg::ResDepth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

endmodule

>>> rtl/utf16le_stream_decoder_unit.sv
// channel | dir | modport | payload                                | beat
// in_i    | in  | sink    | data_byte[7:0], end_of_input           | one raw byte
// out_o   | out | source  | code_unit[15:0], replaced, last_of_run | one code unit
//
// One byte is accepted per cycle while in_i.ready is high; its results (zero, one or
// two) are registered in a four-entry result buffer and, from the next cycle on,
// leave one per cycle while the sink is ready. With the sink always ready the buffer
// never holds more than two results, so a two-result byte does not stall the input.
// in_i.ready drops only while three or more results wait, i.e. when the sink stalls;
// it depends only on the buffer fill, not on out_o.ready.
// Reset clears the pairing state and empties the buffer; there is no clearing pass.
module utf16le_stream_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  u16d_in_if.sink    in_i,
  u16d_out_if.source out_o
);

  logic [7:0]      low_q, low_d;
  logic            odd_q, odd_d;
  logic [15:0]     hold_q, hold_d;
  logic            pend_q, pend_d;
  logic            acc, pop, free;
  logic [15:0]     unit;
  u16d_pkg::push_t push;
  u16d_pkg::res_t  head;

  assign acc  = in_i.valid && in_i.ready;
  assign pop  = out_o.valid && out_o.ready;
  assign unit = {in_i.data_byte, low_q};

  // byte pairing and surrogate checks for the incoming beat
  always_comb begin
    low_d  = low_q;
    odd_d  = odd_q;
    hold_d = hold_q;
    pend_d = pend_q;
    push   = '0;
    if (acc) begin
      if (!odd_q) begin
        low_d = in_i.data_byte;
        odd_d = 1'b1;
      end else begin
        low_d = '0;
        odd_d = 1'b0;
        priority if (pend_q) begin
          if (u16d_pkg::is_low(unit)) begin
            push.first  = '{code_unit: hold_q, replaced: 1'b0, last_of_run: 1'b0};
            push.second = '{code_unit: unit, replaced: 1'b0, last_of_run: 1'b1};
            push.num    = 2'd2;
          end else begin
            push.first = '{code_unit: u16d_pkg::ReplUnit, replaced: 1'b1, last_of_run: 1'b1};
            push.num   = 2'd1;
          end
          pend_d = 1'b0;
          hold_d = '0;
        end else if (unit == u16d_pkg::SwappedMark) begin
          push.first = '{code_unit: u16d_pkg::ReplUnit, replaced: 1'b1, last_of_run: 1'b1};
          push.num   = 2'd1;
        end else if (u16d_pkg::is_high(unit)) begin
          hold_d = unit;
          pend_d = 1'b1;
        end else if (u16d_pkg::is_low(unit)) begin
          push.first = '{code_unit: u16d_pkg::ReplUnit, replaced: 1'b1, last_of_run: 1'b1};
          push.num   = 2'd1;
        end else begin
          push.first = '{code_unit: unit, replaced: 1'b0, last_of_run: 1'b1};
          push.num   = 2'd1;
        end
      end
      // end of string: leftover byte or dangling high surrogate
      if (in_i.end_of_input) begin
        if (odd_d || pend_d) begin
          push.first = '{code_unit: u16d_pkg::ReplUnit, replaced: 1'b1, last_of_run: 1'b1};
          push.num   = 2'd1;
        end
        low_d  = '0;
        odd_d  = 1'b0;
        hold_d = '0;
        pend_d = 1'b0;
      end
    end
  end

  // pairing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      odd_q  <= 1'b0;
      hold_q <= '0;
      pend_q <= 1'b0;
    end else begin
      low_q  <= low_d;
      odd_q  <= odd_d;
      hold_q <= hold_d;
      pend_q <= pend_d;
    end
  end

  // result buffer
  u16d_res_buf u_res_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .free_o  (free),
    .valid_o (out_o.valid),
    .head_o  (head)
  );

  assign in_i.ready        = free;
  assign out_o.code_unit   = head.code_unit;
  assign out_o.replaced    = head.replaced;
  assign out_o.last_of_run = head.last_of_run;

endmodule

>>> rtl/u16d_checker.sv
module u16d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_code_unit_i,
  input logic        out_replaced_i,
  input logic        out_last_of_run_i
);

  // a stalled result beat stays offered with the same payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_code_unit_i)
      && $stable(out_replaced_i) && $stable(out_last_of_run_i))
    else $error("result beat dropped or changed while stalled");

  // a replacement always carries the replacement character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_replaced_i |-> out_code_unit_i == u16d_pkg::ReplUnit)
    else $error("replacement with wrong code unit");

  // a passed high surrogate never ends a run, since its low partner follows it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_replaced_i && u16d_pkg::is_high(out_code_unit_i)
      |-> !out_last_of_run_i)
    else $error("high surrogate ends a run");

  // nothing is offered right after reset, and input is open
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i && in_ready_i)
    else $error("buffer not empty after reset");

  // a byte is only held back while results wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i)
    else $error("input blocked with empty buffer");

endmodule

bind utf16le_stream_decoder_unit u16d_checker u_u16d_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_code_unit_i   (out_o.code_unit),
  .out_replaced_i    (out_o.replaced),
  .out_last_of_run_i (out_o.last_of_run)
);

>>> bench/utf16le_stream_decoder_unit_tb.sv
module utf16le_stream_decoder_unit_tb;

  // one raw byte to send, with an optional hand-written expectation
  typedef struct packed {
    logic [7:0]  b;
    logic        eoi;
    logic        typed;
    logic [15:0] unit;
    logic        repl;
  } byte_item_t;

  localparam int unsigned NumDirected = 26;
  localparam int unsigned NumRandom   = 1550;

  // hand-picked bytes: extremes, marks, surrogate cases, string ends
  byte_item_t dir_rows [NumDirected] = '{
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b1, 16'h0000, 1'b0},  // lowest unit
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 16'hFFFF, 1'b0},  // highest unit
    '{8'hFE, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, u16d_pkg::ReplUnit, 1'b1},  // byte-reversed mark
    '{8'hFD, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, u16d_pkg::ReplUnit, 1'b0},  // replacement char itself passes
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hDC, 1'b0, 1'b1, u16d_pkg::ReplUnit, 1'b1},  // lone low surrogate
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hD8, 1'b0, 1'b0, 16'h0000, 1'b0},  // high surrogate held back
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hDF, 1'b0, 1'b0, 16'h0000, 1'b0},  // valid pair, two units
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hDB, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hD8, 1'b0, 1'b1, u16d_pkg::ReplUnit, 1'b1},  // high then high
    '{8'h41, 1'b1, 1'b1, u16d_pkg::ReplUnit, 1'b1},  // odd byte at end
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hD8, 1'b1, 1'b1, u16d_pkg::ReplUnit, 1'b1},  // dangling high at end
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hDB, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h7F, 1'b1, 1'b1, u16d_pkg::ReplUnit, 1'b1},  // dangling high plus odd byte
    '{8'h41, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b1, 1'b1, 16'h0041, 1'b0}   // plain unit closing a string
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  u16d_in_if  byte_if ();
  u16d_out_if unit_if ();

  utf16le_stream_decoder_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (unit_if)
  );

  always #1 clk_i = ~clk_i;

  // decoder shadow state
  logic [7:0]  lo_byte  = '0;
  logic        odd_pend = 1'b0;
  logic [15:0] hi_unit  = '0;
  logic        hi_pend  = 1'b0;

  u16d_pkg::res_t units_due [$];
  int   mismatches   = 0;
  int   bytes_sent   = 0;
  int   strings_sent = 0;
  int   units_seen   = 0;
  int   repl_seen    = 0;
  int   pairs_seen   = 0;
  int   burst_left   = 0;

  // append one expected unit behind the others
  function automatic void queue_unit(input u16d_pkg::res_t r);
    units_due = {units_due, r};
  endfunction

  // code units that one byte produces, updating the shadow state
  function automatic int decode_byte(input logic [7:0] b, input logic eoi,
                                     output u16d_pkg::res_t outs [2]);
    int          n;
    logic [15:0] u;
    n = 0;
    outs[0] = '0;
    outs[1] = '0;
    if (!odd_pend) begin
      lo_byte  = b;
      odd_pend = 1'b1;
    end else begin
      u        = {b, lo_byte};
      odd_pend = 1'b0;
      lo_byte  = '0;
      if (hi_pend) begin
        if (u >= u16d_pkg::LoSurFirst && u <= u16d_pkg::LoSurLast) begin
          outs[0] = '{hi_unit, 1'b0, 1'b0};
          outs[1] = '{u, 1'b0, 1'b0};
          n = 2;
        end else begin
          outs[0] = '{u16d_pkg::ReplUnit, 1'b1, 1'b0};
          n = 1;
        end
        hi_pend = 1'b0;
        hi_unit = '0;
      end else if (u == u16d_pkg::SwappedMark) begin
        outs[0] = '{u16d_pkg::ReplUnit, 1'b1, 1'b0};
        n = 1;
      end else if (u >= u16d_pkg::HiSurFirst && u <= u16d_pkg::HiSurLast) begin
        hi_unit = u;
        hi_pend = 1'b1;
      end else if (u >= u16d_pkg::LoSurFirst && u <= u16d_pkg::LoSurLast) begin
        outs[0] = '{u16d_pkg::ReplUnit, 1'b1, 1'b0};
        n = 1;
      end else begin
        outs[0] = '{u, 1'b0, 1'b0};
        n = 1;
      end
    end
    // string end flushes whatever is left as one replacement
    if (eoi) begin
      if (odd_pend || hi_pend) begin
        outs[n] = '{u16d_pkg::ReplUnit, 1'b1, 1'b0};
        n++;
      end
      lo_byte  = '0;
      odd_pend = 1'b0;
      hi_unit  = '0;
      hi_pend  = 1'b0;
    end
    if (n > 0) outs[n-1].last_of_run = 1'b1;
    return n;
  endfunction

  // drive one beat in bursts with random gaps, log its units on acceptance
  task automatic send_byte(input byte_item_t it);
    u16d_pkg::res_t outs [2];
    u16d_pkg::res_t typed_unit;
    int   n;
    int   gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    byte_if.valid        <= 1'b1;
    byte_if.data_byte    <= it.b;
    byte_if.end_of_input <= it.eoi;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    n = decode_byte(it.b, it.eoi, outs);
    if (it.typed) begin
      typed_unit = '{it.unit, it.repl, 1'b1};
      queue_unit(typed_unit);
    end else begin
      for (int i = 0; i < n; i++) queue_unit(outs[i]);
    end
    if (n == 2 && !outs[0].replaced && !outs[1].replaced) pairs_seen++;
    if (it.eoi) strings_sent++;
    bytes_sent++;
  endtask

  // hold the input off until every pending unit has come out
  task automatic hold_until_drained();
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (units_due.size() != 0);
    burst_left = 0;
  endtask

  // one string: mostly well-formed units, sometimes raw noise
  task automatic send_string();
    logic [7:0]  bytes_q [$];
    logic [15:0] u;
    int          n_units;
    byte_item_t  it;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 7)) bytes_q = {bytes_q, 8'($urandom)};
    end else begin
      n_units = $urandom_range(0, 6);
      for (int k = 0; k < n_units; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: u = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 16'hD7FF))
                                                      : 16'($urandom_range(16'hE000, 16'hFFFF));
          4, 5: begin
            u = 16'($urandom_range(u16d_pkg::HiSurFirst, u16d_pkg::HiSurLast));
            bytes_q = {bytes_q, u[7:0]};
            bytes_q = {bytes_q, u[15:8]};
            u = 16'($urandom_range(u16d_pkg::LoSurFirst, u16d_pkg::LoSurLast));
          end
          6: u = 16'($urandom_range(u16d_pkg::LoSurFirst, u16d_pkg::LoSurLast));
          7: u = 16'($urandom_range(u16d_pkg::HiSurFirst, u16d_pkg::HiSurLast));
          8: begin
            case ($urandom_range(0, 3))
              0: u = u16d_pkg::SwappedMark;
              1: u = u16d_pkg::ReplUnit;
              2: u = 16'h0000;
              default: u = 16'hFFFF;
            endcase
          end
          default: u = 16'($urandom);
        endcase
        bytes_q = {bytes_q, u[7:0]};
        bytes_q = {bytes_q, u[15:8]};
      end
      // trailing odd byte, always when no unit was drawn
      if (n_units == 0 || $urandom_range(0, 5) == 0) bytes_q = {bytes_q, 8'($urandom)};
    end
    for (int i = 0; i < bytes_q.size(); i++) begin
      it = '{bytes_q[i], (i == bytes_q.size() - 1), 1'b0, 16'h0000, 1'b0};
      send_byte(it);
    end
  endtask

  // receiver stall pattern, rotated by one bit and reshuffled when its countdown runs out
  logic [15:0] stall_pat = '1;
  int          pat_left  = 0;

  always @(posedge clk_i) begin
    if (pat_left == 0) begin
      pat_left <= 64;
      case ($urandom_range(0, 3))
        0: stall_pat <= '1;
        1: stall_pat <= 16'($urandom) | 16'h0001;
        2: stall_pat <= 16'h8888;
        default: stall_pat <= 16'h00FF;
      endcase
    end else begin
      pat_left  <= pat_left - 1;
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
    unit_if.ready <= stall_pat[15];
  end

  // compare each accepted unit with the oldest expectation
  always @(posedge clk_i) begin
    u16d_pkg::res_t want;
    if (rst_ni && unit_if.valid && unit_if.ready) begin
      units_seen++;
      if (unit_if.replaced) repl_seen++;
      if (units_due.size() == 0) begin
        $error("unexpected code unit %h", unit_if.code_unit);
        mismatches++;
      end else begin
        want = units_due.pop_front();
        if (unit_if.code_unit !== want.code_unit) begin
          $error("code_unit: expected %h, got %h", want.code_unit, unit_if.code_unit);
          mismatches++;
        end
        if (unit_if.replaced !== want.replaced) begin
          $error("replaced: expected %b, got %b", want.replaced, unit_if.replaced);
          mismatches++;
        end
        if (unit_if.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, unit_if.last_of_run);
          mismatches++;
        end
      end
    end
  end

  // overall time limit
  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

  // reset, directed rows, random strings, wind-down
  initial begin
    int  waited;
    bit  paused;
    rst_ni               = 1'b0;
    byte_if.valid        = 1'b0;
    byte_if.data_byte    = '0;
    byte_if.end_of_input = 1'b0;
    unit_if.ready        = 1'b0;
    paused               = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirected; i++) send_byte(dir_rows[i]);
    hold_until_drained();

    while (bytes_sent < NumDirected + NumRandom) begin
      send_string();
      if (!paused && bytes_sent > NumDirected + NumRandom / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
    byte_if.valid <= 1'b0;

    waited = 0;
    while (units_due.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (units_due.size() != 0) begin
      $error("%0d code units never arrived", units_due.size());
      mismatches++;
    end
    repeat (20) @(posedge clk_i);

    $display("covered %0d bytes in %0d strings, %0d code units checked",
             bytes_sent, strings_sent, units_seen);
    $display("  %0d replacements, %0d surrogate pairs passed through", repl_seen, pairs_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/u16d_pkg.sv
rtl/u16d_if.sv
rtl/u16d_res_buf.sv
rtl/utf16le_stream_decoder_unit.sv
rtl/u16d_checker.sv
bench/utf16le_stream_decoder_unit_tb.sv
